[hdl/clcd_pkg.sv]
package clcd_pkg;

    // Default panel geometry.
    localparam int ROWS_DEF    = 4;
    localparam int COLUMNS_DEF = 20;

    // Field widths of the items.
    localparam int ROW_W  = 2;
    localparam int COL_W  = 5;
    localparam int CHAR_W = 8;
    localparam int REQ_W  = 2;
    localparam int BYTE_W = 8;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FORCE = 2'd2;

    // Expander bit assignments and the set-cursor opcode.
    localparam logic [BYTE_W-1:0] BACKLIGHT  = 8'h08;
    localparam logic [BYTE_W-1:0] ENABLE     = 8'h04;
    localparam logic [BYTE_W-1:0] CURSOR_CMD = 8'h80;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr_des;     // store a desired cell from the input item
        logic clr;        // forget the shadow and home the scan
        logic start;      // begin a scan
        logic rd;         // read the cell at the scan position and advance
        logic mark;       // record the read cell as shown, prime the byte sequence
        logic load_byte;  // put the next expander byte into the output register
        logic load_idle;  // put the idle result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic dirty;      // the cell just read differs from its shadow
        logic done;       // every cell has been examined
        logic out_free;   // the output register can take a result now
        logic byte_last;  // the next byte is the twelfth of the sequence
    } t_status;

    // DDRAM address of the first column of each row.
    function automatic logic [BYTE_W-1:0] row_base(input logic [ROW_W-1:0] row);
        logic [BYTE_W-1:0] base;
        case (row)
            2'd0:    base = 8'h00;
            2'd1:    base = 8'h40;
            2'd2:    base = 8'h14;
            2'd3:    base = 8'h54;
            default: base = 8'h00;
        endcase
        return base;
    endfunction

endpackage

[hdl/char_lcd_dirty_cell_refresher.sv]
// Character LCD refresher for an HD44780-class panel run in 4-bit mode behind
// an I/O expander. The block holds a ROWS x COLUMNS buffer of desired
// characters and a shadow of what the panel already shows. Write items store a
// desired cell (out-of-range cells are dropped). A force refresh item forgets
// the shadow and homes the scan to row 0, column 0. A tick item walks the cells
// from the scan position, wrapping around, and at the first cell that differs
// from its shadow emits twelve expander bytes: the set-cursor command with rs
// low and then the character with rs high, each as high and low nibble, each
// nibble as plain, enable-high and enable-low bytes, all with the backlight
// bit set; the last byte carries tlast. A tick that finds nothing dirty emits
// one idle item with tuser low, tdata zero and tlast high. A tick examines the
// cells one by one, each with a registered memory read and then a compare, and
// its output waits while the sink holds back. A new item is taken as soon as
// the last byte sits in the output register. Reset takes effect at once: both
// buffers read as all zero through per-cell valid bits.
module char_lcd_dirty_cell_refresher #(
    parameter int ROWS    = clcd_pkg::ROWS_DEF,
    parameter int COLUMNS = clcd_pkg::COLUMNS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // cell_row[1:0], cell_column[6:2], char_code[14:7], zero
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    // Expander byte channel.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // expander_byte[7:0]
    output logic        m_axis_tuser,   // byte_valid[0]
    output logic        m_axis_tlast
);

    clcd_pkg::t_cmd    w_cmd;
    clcd_pkg::t_status w_status;

    // The controller sequences the scan and the byte stream; the datapath holds
    // the buffers, scan position, byte counters and the output register.
    clcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req_type (s_axis_tuser),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    clcd_dp #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cell_row       (s_axis_tdata[1:0]),
        .i_cell_column    (s_axis_tdata[6:2]),
        .i_char_code      (s_axis_tdata[14:7]),
        .i_out_ready      (m_axis_tready),
        .o_status         (w_status),
        .o_out_valid      (m_axis_tvalid),
        .o_out_byte       (m_axis_tdata),
        .o_out_byte_valid (m_axis_tuser),
        .o_out_last       (m_axis_tlast)
    );

endmodule

[hdl/clcd_ctrl.sv]
module clcd_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [clcd_pkg::REQ_W-1:0] i_req_type,
    input  clcd_pkg::t_status          i_status,
    output logic                       o_in_ready,
    output clcd_pkg::t_cmd             o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_CMP   = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_req_type)
                        clcd_pkg::REQ_WRITE: o_cmd.wr_des = 1'b1;
                        clcd_pkg::REQ_FORCE: o_cmd.clr = 1'b1;
                        clcd_pkg::REQ_TICK: begin
                            o_cmd.start = 1'b1;
                            n_state     = ST_READ;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_CMP;
            end
            ST_CMP: begin
                if (i_status.dirty) begin
                    o_cmd.mark = 1'b1;
                    n_state    = ST_EMIT;
                end else if (i_status.done) begin
                    n_state = ST_EMPTY;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_byte = 1'b1;
                    if (i_status.byte_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_EMPTY: begin
                if (i_status.out_free) begin
                    o_cmd.load_idle = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hdl/clcd_dp.sv]
module clcd_dp #(
    parameter int ROWS    = clcd_pkg::ROWS_DEF,
    parameter int COLUMNS = clcd_pkg::COLUMNS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  clcd_pkg::t_cmd              i_cmd,
    input  logic [clcd_pkg::ROW_W-1:0]  i_cell_row,
    input  logic [clcd_pkg::COL_W-1:0]  i_cell_column,
    input  logic [clcd_pkg::CHAR_W-1:0] i_char_code,
    input  logic                        i_out_ready,
    output clcd_pkg::t_status           o_status,
    output logic                        o_out_valid,
    output logic [clcd_pkg::BYTE_W-1:0] o_out_byte,
    output logic                        o_out_byte_valid,
    output logic                        o_out_last
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W = $clog2(CELLS + 1);

    // Character stores; an entry whose valid bit is clear reads as zero.
    logic [clcd_pkg::CHAR_W-1:0] r_des_mem [CELLS];
    logic [clcd_pkg::CHAR_W-1:0] r_shn_mem [CELLS];
    logic [CELLS-1:0]            r_des_vld;
    logic [CELLS-1:0]            r_shn_vld;

    logic [clcd_pkg::CHAR_W-1:0] r_des_q;
    logic [clcd_pkg::CHAR_W-1:0] r_shn_q;
    logic                        r_des_qv;
    logic                        r_shn_qv;

    logic [clcd_pkg::ROW_W-1:0]  r_scan_row;
    logic [clcd_pkg::COL_W-1:0]  r_scan_col;
    logic [clcd_pkg::ROW_W-1:0]  r_cur_row;
    logic [clcd_pkg::COL_W-1:0]  r_cur_col;
    logic [IDX_W-1:0]            r_cur_idx;
    logic [CNT_W-1:0]            r_count;

    logic [1:0]                  r_nib;
    logic [1:0]                  r_phase;

    logic                        r_out_valid;
    logic [clcd_pkg::BYTE_W-1:0] r_out_byte;
    logic                        r_out_byte_valid;
    logic                        r_out_last;

    logic                        w_in_range;
    logic [IDX_W-1:0]            w_wr_idx;
    logic [IDX_W-1:0]            w_scan_idx;
    logic [clcd_pkg::CHAR_W-1:0] w_des;
    logic [clcd_pkg::CHAR_W-1:0] w_shn;
    logic [clcd_pkg::BYTE_W-1:0] w_cursor;
    logic [3:0]                  w_nib_val;
    logic [clcd_pkg::BYTE_W-1:0] w_byte;
    logic                        w_byte_last;
    logic                        w_out_free;

    assign w_in_range = (int'(i_cell_row) < ROWS) && (int'(i_cell_column) < COLUMNS);
    assign w_wr_idx   = IDX_W'(int'(i_cell_row) * COLUMNS + int'(i_cell_column));
    assign w_scan_idx = IDX_W'(int'(r_scan_row) * COLUMNS + int'(r_scan_col));

    assign w_des = r_des_qv ? r_des_q : '0;
    assign w_shn = r_shn_qv ? r_shn_q : '0;

    assign w_cursor = clcd_pkg::CURSOR_CMD |
                      (clcd_pkg::BYTE_W'(r_cur_col) + clcd_pkg::row_base(r_cur_row));

    // Nibbles go out command high, command low, character high, character low.
    always_comb begin
        case (r_nib)
            2'd0:    w_nib_val = w_cursor[7:4];
            2'd1:    w_nib_val = w_cursor[3:0];
            2'd2:    w_nib_val = w_des[7:4];
            2'd3:    w_nib_val = w_des[3:0];
            default: w_nib_val = 4'd0;
        endcase
    end

    assign w_byte = {w_nib_val, 4'd0} | clcd_pkg::BACKLIGHT |
                    ((r_phase == 2'd1) ? clcd_pkg::ENABLE : '0) |
                    clcd_pkg::BYTE_W'(r_nib[1]);
    assign w_byte_last = (r_nib == 2'd3) && (r_phase == 2'd2);
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign o_status.dirty     = (w_des != w_shn);
    assign o_status.done      = (r_count == CNT_W'(CELLS));
    assign o_status.out_free  = w_out_free;
    assign o_status.byte_last = w_byte_last;

    // Memory write and read ports.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_des && w_in_range) begin
            r_des_mem[w_wr_idx] <= i_char_code;
        end
        if (i_cmd.mark) begin
            r_shn_mem[r_cur_idx] <= w_des;
        end
        if (i_cmd.rd) begin
            r_des_q   <= r_des_mem[w_scan_idx];
            r_shn_q   <= r_shn_mem[w_scan_idx];
            r_cur_idx <= w_scan_idx;
            r_cur_row <= r_scan_row;
            r_cur_col <= r_scan_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_des_vld  <= '0;
            r_shn_vld  <= '0;
            r_des_qv   <= 1'b0;
            r_shn_qv   <= 1'b0;
            r_scan_row <= '0;
            r_scan_col <= '0;
            r_count    <= '0;
            r_nib      <= '0;
            r_phase    <= '0;
        end else begin
            if (i_cmd.wr_des && w_in_range) begin
                r_des_vld[w_wr_idx] <= 1'b1;
            end
            if (i_cmd.clr) begin
                r_shn_vld  <= '0;
                r_scan_row <= '0;
                r_scan_col <= '0;
            end
            if (i_cmd.start) begin
                r_count <= '0;
            end
            if (i_cmd.rd) begin
                r_des_qv <= r_des_vld[w_scan_idx];
                r_shn_qv <= r_shn_vld[w_scan_idx];
                r_count  <= r_count + 1'b1;
                if (int'(r_scan_col) + 1 >= COLUMNS) begin
                    r_scan_col <= '0;
                    if (int'(r_scan_row) + 1 >= ROWS) begin
                        r_scan_row <= '0;
                    end else begin
                        r_scan_row <= r_scan_row + 1'b1;
                    end
                end else begin
                    r_scan_col <= r_scan_col + 1'b1;
                end
            end
            if (i_cmd.mark) begin
                r_shn_vld[r_cur_idx] <= 1'b1;
                r_nib                <= '0;
                r_phase              <= '0;
            end
            if (i_cmd.load_byte) begin
                if (r_phase == 2'd2) begin
                    r_phase <= '0;
                    r_nib   <= r_nib + 1'b1;
                end else begin
                    r_phase <= r_phase + 1'b1;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_byte || i_cmd.load_idle) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_out_byte       <= w_byte;
            r_out_byte_valid <= 1'b1;
            r_out_last       <= w_byte_last;
        end else if (i_cmd.load_idle) begin
            r_out_byte       <= '0;
            r_out_byte_valid <= 1'b0;
            r_out_last       <= 1'b1;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_out_byte_valid = r_out_byte_valid;
    assign o_out_last       = r_out_last;

endmodule

[hdl/clcd_checker.sv]
module clcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled output item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled output item changed");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // An idle item is a single zero item that ends its sequence.
    a_idle_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'h00))
        else $error("malformed idle item");

    // Data bytes always carry the backlight and never the unused bit.
    a_data_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[3] && !m_axis_tdata[1])
        else $error("data byte with bad control bits");

    // A sequence ends on an enable-low byte.
    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser && m_axis_tdata[2] |-> !m_axis_tlast)
        else $error("sequence ends with enable high");

endmodule

bind char_lcd_dirty_cell_refresher clcd_checker u_clcd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
